### hdl/fwp_pkg.sv
package fwp_pkg;

    // Defaults for the top-level parameters
    localparam int PACKET_SIZE_DEF = 128;
    localparam int CMD_LEN_DEF     = 16;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Framing and tag characters
    localparam logic [7:0] CH_START = 8'h24; // '$'
    localparam logic [7:0] CH_STOP  = 8'h23; // '#'
    localparam logic [7:0] CH_UC_R  = 8'h52;
    localparam logic [7:0] CH_UC_I  = 8'h49;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_W  = 8'h57;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_V  = 8'h56;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_UC_D  = 8'h44;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_M  = 8'h6D;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Packet kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_RIFF  = 3'd1;
    localparam logic [2:0] KIND_FMT   = 3'd2;
    localparam logic [2:0] KIND_DHDR  = 3'd3;
    localparam logic [2:0] KIND_DBLK  = 3'd4;
    localparam logic [2:0] KIND_CMD   = 3'd5;

    // Field step within a data block that carries the payload
    localparam logic [2:0] STEP_PAYLOAD = 3'd3;

    // Classification of one received byte
    typedef struct packed {
        logic       is_start;
        logic       is_stop;
        logic [2:0] kind;        // packet kind if used as a type byte
        logic       riff_letter;
        logic       wave_letter;
        logic       fmt_letter;
        logic       data_letter;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        byte_class_t cls;
    } queue_item_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic        field_valid;
        logic [3:0]  field_id;
        logic [31:0] field_value;
        logic        payload_valid;
        logic [6:0]  payload_index;
        logic [7:0]  payload_byte;
        logic        command_valid;
        logic [3:0]  command_index;
        logic [7:0]  command_byte;
        logic        packet_done;
    } result_t;

    // Width in bytes of a header field; kidx is packet kind minus one
    function automatic logic [2:0] step_width(input logic [1:0] kidx, input logic [2:0] step);
        logic [2:0] w;
        w = 3'd0;
        unique case (kidx)
            2'd0: w = (step < 3'd3) ? 3'd4 : 3'd0;
            2'd1:
            begin
                unique case (step)
                    3'd0, 3'd1, 3'd4, 3'd5: w = 3'd4;
                    default:                w = 3'd2;
                endcase
            end
            2'd2: w = (step < 3'd2) ? 3'd4 : 3'd0;
            default:
            begin
                unique case (step)
                    3'd0, 3'd2: w = 3'd2;
                    3'd1:       w = 3'd1;
                    default:    w = 3'd0;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic logic [3:0] step_count(input logic [1:0] kidx);
        logic [3:0] c;
        unique case (kidx)
            2'd0:    c = 4'd3;
            2'd1:    c = 4'd8;
            2'd2:    c = 4'd2;
            default: c = 4'd3;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] first_id(input logic [1:0] kidx);
        logic [3:0] f;
        unique case (kidx)
            2'd0:    f = 4'd0;
            2'd1:    f = 4'd3;
            2'd2:    f = 4'd11;
            default: f = 4'd13;
        endcase
        return f;
    endfunction

endpackage

### hdl/fwp_front.sv
module fwp_front
    import fwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output queue_item_t out_item
);

    logic        valid_reg;
    queue_item_t item_reg;
    byte_class_t cls;

    // Decode the byte into the flags the parser needs
    always_comb
    begin
        cls.is_start    = (in_byte == CH_START);
        cls.is_stop     = (in_byte == CH_STOP);
        cls.riff_letter = (in_byte == CH_UC_R) || (in_byte == CH_UC_I) || (in_byte == CH_UC_F);
        cls.wave_letter = (in_byte == CH_UC_W) || (in_byte == CH_UC_A) ||
                          (in_byte == CH_UC_V) || (in_byte == CH_UC_E);
        cls.fmt_letter  = (in_byte == CH_LC_F) || (in_byte == CH_LC_M) ||
                          (in_byte == CH_LC_T) || (in_byte == CH_SPACE);
        cls.data_letter = (in_byte == CH_LC_D) || (in_byte == CH_LC_A) || (in_byte == CH_LC_T);
        priority if (in_byte == CH_UC_R)
            cls.kind = KIND_RIFF;
        else if (in_byte == CH_LC_F)
            cls.kind = KIND_FMT;
        else if (in_byte == CH_LC_D)
            cls.kind = KIND_DHDR;
        else if (in_byte == CH_UC_D)
            cls.kind = KIND_DBLK;
        else if (in_byte == CH_UC_C)
            cls.kind = KIND_CMD;
        else
            cls.kind = KIND_NONE;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= '{rx_byte: in_byte, cls: cls};
        end
    end

endmodule

### hdl/fwp_queue.sv
module fwp_queue
    import fwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  queue_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output queue_item_t out_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    queue_item_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### hdl/fwp_back.sv
module fwp_back
    import fwp_pkg::*;
#(
    parameter int PACKET_SIZE = PACKET_SIZE_DEF,
    parameter int CMD_LEN     = CMD_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  queue_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_result
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_TYPE  = 3'd1,
        PH_BODY  = 3'd2,
        PH_CMD   = 3'd3,
        PH_STOP  = 3'd4
    } phase_t;

    localparam logic [7:0] PKT_SIZE_W = 8'(PACKET_SIZE);
    localparam logic [6:0] CMD_LEN_W  = 7'(CMD_LEN);

    phase_t      phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  step_reg, step_next;
    logic [6:0]  count_reg, count_next;
    logic [31:0] word_reg, word_next;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     res;
    logic        take;
    logic        done;
    logic [1:0]  kidx;
    logic        letter_ok;
    logic [31:0] word_sum;
    logic [6:0]  count_inc;
    logic [3:0]  step_inc;
    logic [7:0]  pay_inc;
    logic [7:0]  b;

    assign in_ready   = !out_valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign b         = in_item.rx_byte;
    assign kidx      = 2'(kind_reg - 3'd1);
    assign count_inc = count_reg + 7'd1;
    assign step_inc  = {1'b0, step_reg} + 4'd1;
    assign pay_inc   = {1'b0, count_reg} + 8'd1;

    always_comb
    begin
        unique case (count_reg[1:0])
            2'd0: word_sum = word_reg | {24'd0, b};
            2'd1: word_sum = word_reg | {16'd0, b, 8'd0};
            2'd2: word_sum = word_reg | {8'd0, b, 16'd0};
            default: word_sum = word_reg | {b, 24'd0};
        endcase
    end

    always_comb
    begin
        priority if (kind_reg == KIND_RIFF && step_reg == 3'd0)
            letter_ok = in_item.cls.riff_letter;
        else if (kind_reg == KIND_RIFF && step_reg == 3'd2)
            letter_ok = in_item.cls.wave_letter;
        else if (kind_reg == KIND_FMT && step_reg == 3'd0)
            letter_ok = in_item.cls.fmt_letter;
        else if (kind_reg == KIND_DHDR && step_reg == 3'd0)
            letter_ok = in_item.cls.data_letter;
        else
            letter_ok = 1'b1;
    end

    // Next parser state and the result for the byte at the queue head
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        count_next = count_reg;
        word_next  = word_reg;
        res        = '0;
        done       = 1'b0;

        unique case (phase_reg)
            PH_START:
            begin
                if (in_item.cls.is_start)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (in_item.cls.kind != KIND_NONE)
                begin
                    kind_next  = in_item.cls.kind;
                    step_next  = '0;
                    count_next = '0;
                    word_next  = '0;
                    phase_next = (in_item.cls.kind == KIND_CMD) ? PH_CMD : PH_BODY;
                end
            end
            PH_BODY:
            begin
                priority if (kind_reg < KIND_RIFF || kind_reg > KIND_DBLK)
                begin
                    phase_next = PH_START;
                    kind_next  = KIND_NONE;
                    step_next  = '0;
                    count_next = '0;
                    word_next  = '0;
                end
                else if (kind_reg == KIND_DBLK && step_reg == STEP_PAYLOAD)
                begin
                    res.payload_valid = 1'b1;
                    res.payload_index = count_reg;
                    res.payload_byte  = b;
                    if (pay_inc >= PKT_SIZE_W)
                    begin
                        count_next = '0;
                        step_next  = '0;
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else if ({1'b0, step_reg} >= step_count(kidx) || count_reg > 7'd3)
                begin
                    step_next  = '0;
                    count_next = '0;
                    word_next  = '0;
                end
                else if (letter_ok)
                begin
                    if (count_inc >= {4'd0, step_width(kidx, step_reg)})
                    begin
                        res.field_valid = 1'b1;
                        res.field_id    = 4'(first_id(kidx) + {1'b0, step_reg});
                        res.field_value = word_sum;
                        word_next       = '0;
                        count_next      = '0;
                        step_next       = step_inc[2:0];
                        if (step_inc >= step_count(kidx) && kind_reg != KIND_DBLK)
                        begin
                            step_next  = '0;
                            phase_next = PH_STOP;
                        end
                    end
                    else
                    begin
                        word_next  = word_sum;
                        count_next = count_inc;
                    end
                end
            end
            PH_CMD:
            begin
                if (in_item.cls.is_stop)
                begin
                    done = 1'b1;
                end
                else if (count_reg < CMD_LEN_W)
                begin
                    res.command_valid = 1'b1;
                    res.command_index = count_reg[3:0];
                    res.command_byte  = b;
                    count_next        = count_inc;
                end
            end
            PH_STOP:
            begin
                done = in_item.cls.is_stop;
            end
            default:
            begin
                phase_next = PH_START;
                kind_next  = KIND_NONE;
                step_next  = '0;
                count_next = '0;
                word_next  = '0;
            end
        endcase

        // Report the kind before a closing stop clears it
        res.frame_kind = kind_next;
        if (done)
        begin
            res.packet_done = 1'b1;
            phase_next      = PH_START;
            kind_next       = KIND_NONE;
            step_next       = '0;
            count_next      = '0;
            word_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            kind_reg      <= KIND_NONE;
            step_reg      <= '0;
            count_reg     <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                step_reg   <= step_next;
                count_reg  <= count_next;
                word_reg   <= word_next;
                result_reg <= res;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

endmodule

### hdl/framed_wav_upload_parser.sv
// Path: a byte goes through the front register, the queue and the back output register.
// Throughput: one byte per cycle while m_axis_tready holds; the front register, the two-entry
// queue and the back output register each pass one transfer a cycle.
// Reset: asynchronous, active low; clears all handshake state and returns the
// parser to waiting for the start byte with no packet open.
module framed_wav_upload_parser
    import fwp_pkg::*;
#(
    parameter int PACKET_SIZE = PACKET_SIZE_DEF, // payload bytes per data block, 1..128
    parameter int CMD_LEN     = CMD_LEN_DEF      // stored command characters, 2..16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // parser results, one per received byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [0] field_valid, [4:1] field_id,
                                        // [36:5] field_value, [37] payload_valid,
                                        // [44:38] payload_index, [52:45] payload_byte,
                                        // [53] command_valid, [57:54] command_index,
                                        // [65:58] command_byte, [71:66] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] frame_kind
    output logic        m_axis_tlast    // packet_done
);

    logic        fr_valid;
    logic        fr_ready;
    queue_item_t fr_item;
    logic        q_valid;
    logic        q_ready;
    queue_item_t q_item;
    result_t     result;

    // Front: register the byte together with its character class
    fwp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    // Hold classified bytes so the front keeps taking transfers while the back stalls, until the queue is full
    fwp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back: advance the framing state and register one result per byte
    fwp_back #(
        .PACKET_SIZE (PACKET_SIZE),
        .CMD_LEN     (CMD_LEN)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result, lowest field first
    assign m_axis_tdata = {6'd0,
                           result.command_byte,
                           result.command_index,
                           result.command_valid,
                           result.payload_byte,
                           result.payload_index,
                           result.payload_valid,
                           result.field_value,
                           result.field_id,
                           result.field_valid};
    assign m_axis_tuser = result.frame_kind;
    assign m_axis_tlast = result.packet_done;

endmodule

### tb/sv/framed_wav_upload_parser_tb.sv
`timescale 1ns / 100ps

import fwp_pkg::*;

// Sizes the testbench builds the block with
localparam int BLOCK_BYTES = PACKET_SIZE_DEF;
localparam int CMD_CHARS   = CMD_LEN_DEF;

// First field id of each header kind, and the field steps that hold tags
localparam logic [3:0] FID_RIFF_TAG  = 4'd0;
localparam logic [3:0] FID_FMT_TAG   = 4'd3;
localparam logic [3:0] FID_DATA_TAG  = 4'd11;
localparam logic [3:0] FID_BLOCK_NUM = 4'd13;
localparam int         TAG_STEP      = 0;
localparam int         WAVE_STEP     = 2;

// Per header kind (riff, fmt, data header, data block): fields and their byte widths
localparam int         FIELD_COUNT [4]    = '{3, 8, 2, 3};
localparam logic [3:0] FIRST_FIELD [4]    = '{FID_RIFF_TAG, FID_FMT_TAG, FID_DATA_TAG,
                                              FID_BLOCK_NUM};
localparam int         FIELD_BYTES [4][8] = '{'{4, 4, 4, 0, 0, 0, 0, 0},
                                              '{4, 4, 2, 2, 4, 4, 2, 2},
                                              '{4, 4, 0, 0, 0, 0, 0, 0},
                                              '{2, 1, 2, 0, 0, 0, 0, 0}};

typedef enum logic [2:0] {SEEK_START, SEEK_TYPE, IN_BODY, IN_CMD, SEEK_STOP} frame_phase_t;

class parse_scoreboard;
    result_t      awaited_results[$];
    int           failures;
    frame_phase_t phase;
    logic [2:0]   kind;
    int           step;
    int           nbytes;
    logic [31:0]  word;

    function new();
        failures = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        phase  = SEEK_START;
        kind   = KIND_NONE;
        step   = 0;
        nbytes = 0;
        word   = '0;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function string describe(result_t r);
        return $sformatf("type %0d field %0b/%0d/%h payload %0b/%0d/%h cmd %0b/%0d/%h done %0b",
                         r.frame_kind, r.field_valid, r.field_id, r.field_value,
                         r.payload_valid, r.payload_index, r.payload_byte,
                         r.command_valid, r.command_index, r.command_byte, r.packet_done);
    endfunction

    // Advance the parser by one accepted byte and queue the result it must give.
    // Return whether the byte did anything beyond being dropped before a start byte.
    function bit note_byte(logic [7:0] b);
        result_t    want;
        bit         closed;
        bit         engaged;
        bit         known;
        bit         letter;
        logic [1:0] kidx;
        want    = '0;
        closed  = 1'b0;
        known   = 1'b1;
        engaged = (phase != SEEK_START) || (b == CH_START);
        case (phase)
            SEEK_START:
            begin
                if (b == CH_START)
                    phase = SEEK_TYPE;
            end
            SEEK_TYPE:
            begin
                case (b)
                    CH_UC_R: kind = KIND_RIFF;
                    CH_LC_F: kind = KIND_FMT;
                    CH_LC_D: kind = KIND_DHDR;
                    CH_UC_D: kind = KIND_DBLK;
                    CH_UC_C: kind = KIND_CMD;
                    default: known = 1'b0;
                endcase
                if (known)
                begin
                    step   = 0;
                    nbytes = 0;
                    word   = '0;
                    phase  = (kind == KIND_CMD) ? IN_CMD : IN_BODY;
                end
            end
            IN_BODY:
            begin
                if (kind < KIND_RIFF || kind > KIND_DBLK)
                    clear_frame();
                else if (kind == KIND_DBLK && step == STEP_PAYLOAD)
                begin
                    want.payload_valid = 1'b1;
                    want.payload_index = 7'(nbytes);
                    want.payload_byte  = b;
                    if (nbytes + 1 >= BLOCK_BYTES)
                    begin
                        nbytes = 0;
                        step   = 0;
                        phase  = SEEK_STOP;
                    end
                    else
                        nbytes++;
                end
                else
                begin
                    kidx = 2'(kind - KIND_RIFF);
                    if (step >= FIELD_COUNT[kidx] || nbytes > 3)
                    begin
                        step   = 0;
                        nbytes = 0;
                        word   = '0;
                    end
                    else
                    begin
                        // tag fields only take bytes from their own letter set
                        letter = 1'b1;
                        if (kind == KIND_RIFF && step == TAG_STEP)
                            letter = b inside {CH_UC_R, CH_UC_I, CH_UC_F};
                        else if (kind == KIND_RIFF && step == WAVE_STEP)
                            letter = b inside {CH_UC_W, CH_UC_A, CH_UC_V, CH_UC_E};
                        else if (kind == KIND_FMT && step == TAG_STEP)
                            letter = b inside {CH_LC_F, CH_LC_M, CH_LC_T, CH_SPACE};
                        else if (kind == KIND_DHDR && step == TAG_STEP)
                            letter = b inside {CH_LC_D, CH_LC_A, CH_LC_T};
                        if (letter)
                        begin
                            word = word | (32'(b) << (8 * nbytes));
                            nbytes++;
                            if (nbytes >= FIELD_BYTES[kidx][step])
                            begin
                                want.field_valid = 1'b1;
                                want.field_id    = 4'(FIRST_FIELD[kidx] + 4'(step));
                                want.field_value = word;
                                word   = '0;
                                nbytes = 0;
                                step++;
                                if (step >= FIELD_COUNT[kidx] && kind != KIND_DBLK)
                                begin
                                    step  = 0;
                                    phase = SEEK_STOP;
                                end
                            end
                        end
                    end
                end
            end
            IN_CMD:
            begin
                if (b == CH_STOP)
                    closed = 1'b1;
                else if (nbytes < CMD_CHARS)
                begin
                    want.command_valid = 1'b1;
                    want.command_index = 4'(nbytes);
                    want.command_byte  = b;
                    nbytes++;
                end
            end
            SEEK_STOP:
            begin
                if (b == CH_STOP)
                    closed = 1'b1;
            end
            default: clear_frame();
        endcase
        want.frame_kind = kind;
        if (closed)
        begin
            want.packet_done = 1'b1;
            clear_frame();
        end
        awaited_results.push_back(want);
        return engaged;
    endfunction

    function void check_result(result_t got, logic [5:0] pad);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected result transfer: %s", describe(got));
            return;
        end
        want = awaited_results.pop_front();
        if (got != want || pad != 6'd0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("result mismatch at %0t (pad bits %b)", $realtime, pad);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction
endclass

module framed_wav_upload_parser_tb;

    // Stop the random stream once roughly this many bytes have reached the parser outside the wait for a start byte
    localparam int ITEM_TARGET = 1750;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // [0] field_valid, [4:1] field_id, [36:5] field_value,
                                  // [37] payload_valid, [44:38] payload_index,
                                  // [52:45] payload_byte, [53] command_valid,
                                  // [57:54] command_index, [65:58] command_byte, [71:66] zero
    logic [2:0]  m_axis_tuser;    // [2:0] frame_kind
    logic        m_axis_tlast;    // packet_done

    parse_scoreboard sb;
    bit              idling;      // random gaps and stalls allowed
    int              gap_pct;     // chance in percent of a sender gap before a byte
    int              useful_bytes;

    framed_wav_upload_parser #(
        .PACKET_SIZE (BLOCK_BYTES),
        .CMD_LEN     (CMD_CHARS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one byte from a falling edge and hold it until the transfer happens.
    // Optionally drop tvalid for a burst first, so gaps land anywhere in a packet.
    task automatic send_byte(input logic [7:0] b);
        if (idling && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (sb.note_byte(b))
            useful_bytes++;
        @(negedge clk);
    endtask

    // Send n bytes of a little-endian value, low byte first
    task automatic send_le(input logic [31:0] value, input int n);
        for (int i = 0; i < n; i++)
            send_byte(value[8 * i +: 8]);
    endtask

    // Send a four-letter tag, mostly the proper spelling, sometimes other letters of the
    // set, and now and then with stray bytes, skipped unless they are letters of the set
    task automatic send_tag(input logic [31:0] canon, input logic [31:0] letters,
                            input int nletters);
        bit         noisy;
        int         sel;
        logic [7:0] b;
        noisy = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 4; i++)
        begin
            if (noisy && $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
            begin
                sel = $urandom_range(0, nletters - 1);
                b   = letters[8 * sel +: 8];
            end
            else
                b = canon[8 * i +: 8];
            send_byte(b);
        end
    endtask

    // Field values lean on the extremes now and then
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One packet of the given kind. A garbled one carries a body of random bytes.
    task automatic send_packet(input logic [2:0] kind, input bit garbled);
        logic [7:0] b;
        int         n;
        send_byte(CH_START);
        // unknown type bytes are skipped while the parser waits for a type
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b inside {CH_UC_R, CH_LC_F, CH_LC_D, CH_UC_D, CH_UC_C});
                send_byte(b);
            end
        end
        case (kind)
            KIND_RIFF: send_byte(CH_UC_R);
            KIND_FMT:  send_byte(CH_LC_F);
            KIND_DHDR: send_byte(CH_LC_D);
            KIND_DBLK: send_byte(CH_UC_D);
            default:   send_byte(CH_UC_C);
        endcase
        if (garbled)
        begin
            repeat ($urandom_range(0, 24)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_STOP);
            return;
        end
        case (kind)
            KIND_RIFF:
            begin
                send_tag({CH_UC_F, CH_UC_F, CH_UC_I, CH_UC_R}, {8'h00, CH_UC_F, CH_UC_I, CH_UC_R}, 3);
                send_le(rand_word(), 4);
                send_tag({CH_UC_E, CH_UC_V, CH_UC_A, CH_UC_W}, {CH_UC_E, CH_UC_V, CH_UC_A, CH_UC_W}, 4);
            end
            KIND_FMT:
            begin
                send_tag({CH_SPACE, CH_LC_T, CH_LC_M, CH_LC_F},
                         {CH_SPACE, CH_LC_T, CH_LC_M, CH_LC_F}, 4);
                send_le(rand_word(), 4);
                send_le(rand_word(), 2);
                send_le(rand_word(), 2);
                send_le(rand_word(), 4);
                send_le(rand_word(), 4);
                send_le(rand_word(), 2);
                send_le(rand_word(), 2);
            end
            KIND_DHDR:
            begin
                send_tag({CH_LC_A, CH_LC_T, CH_LC_A, CH_LC_D}, {8'h00, CH_LC_T, CH_LC_A, CH_LC_D}, 3);
                send_le(rand_word(), 4);
            end
            KIND_DBLK:
            begin
                send_le(rand_word(), 2);
                send_le(($urandom_range(0, 3) == 0) ? rand_word() : 32'($urandom_range(0, 1)), 1);
                // the length field is ignored: the payload is always a full block
                send_le(rand_word(), 2);
                repeat (BLOCK_BYTES) send_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                // commands sometimes run past the stored length
                n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, CMD_CHARS)
                                                 : $urandom_range(CMD_CHARS + 1, CMD_CHARS + 6);
                repeat (n)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_STOP);
                    send_byte(b);
                end
                send_byte(CH_STOP);
                return;
            end
        endcase
        // close the packet: usually at once, sometimes after junk, rarely never
        n = $urandom_range(0, 9);
        if (n == 1)
        begin
            repeat ($urandom_range(1, 4))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_STOP);
                send_byte(b);
            end
        end
        if (n != 0)
            send_byte(CH_STOP);
    endtask

    // Receiver: hold tready high for random stretches, and while idling drop it in bursts
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
        end
    end

    // Check every result transfer at the rising edge that completes it
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{frame_kind:    m_axis_tuser,
                              field_valid:   m_axis_tdata[0],
                              field_id:      m_axis_tdata[4:1],
                              field_value:   m_axis_tdata[36:5],
                              payload_valid: m_axis_tdata[37],
                              payload_index: m_axis_tdata[44:38],
                              payload_byte:  m_axis_tdata[52:45],
                              command_valid: m_axis_tdata[53],
                              command_index: m_axis_tdata[57:54],
                              command_byte:  m_axis_tdata[65:58],
                              packet_done:   m_axis_tlast},
                            m_axis_tdata[71:66]);
    end

    // Hard stop, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("framed_wav_upload_parser verification failed");
        $finish;
    end

    initial
    begin
        // Opening bytes: stray bytes and extremes before any start, an unknown type byte,
        // a '$' inside a command, a data header tag with a non-letter in it, an all-ones
        // size and junk before the stop byte
        logic [7:0] opening [23] = '{8'h00, 8'hFF, CH_STOP, CH_UC_R,
                                     CH_START, 8'hFF, CH_UC_C, CH_UC_A, CH_START, CH_STOP,
                                     CH_START, CH_LC_D, CH_LC_D, 8'h00, CH_LC_A, CH_LC_T,
                                     CH_LC_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, CH_STOP};
        bit         drained_once;
        int         pick;
        int         wait_cycles;

        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        idling        = 1'b1;
        gap_pct       = 15;
        useful_bytes  = 0;
        drained_once  = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_byte(opening[i]);

        while (useful_bytes < ITEM_TARGET)
        begin
            // halfway through, hold the sender until every result is in
            if (!drained_once && useful_bytes >= ITEM_TARGET / 2)
            begin
                drained_once = 1'b1;
                s_axis_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (sb.pending() != 0);
            end
            // run the last stretch at full rate on both sides
            if (useful_bytes >= ITEM_TARGET * 17 / 20)
                idling = 1'b0;
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_packet(KIND_RIFF, 1'b0);
            else if (pick < 27)
                send_packet(KIND_FMT, 1'b0);
            else if (pick < 39)
                send_packet(KIND_DHDR, 1'b0);
            else if (pick < 45)
                send_packet(KIND_DBLK, 1'b0);
            else if (pick < 65)
                send_packet(KIND_CMD, 1'b0);
            else if (pick < 85)
                send_packet(3'($urandom_range(KIND_RIFF, KIND_CMD)), 1'b1);
            else
            begin
                // line noise between packets, kept clear of start bytes
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 1) == 0) ? CH_STOP
                                                          : 8'($urandom_range(CH_START + 1, 255)));
            end
        end

        // drop tvalid, wait for the last results, then allow for the pipeline
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 5000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (10) @(negedge clk);

        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("framed_wav_upload_parser verification clean");
        else
            $display("framed_wav_upload_parser verification failed");
        $finish;
    end

endmodule
